### design/png_rf_pkg.sv
// package: shared types and constants of the png row filter
`timescale 1ns / 1ps
`default_nettype none

package png_rf_pkg;

    localparam int MAX_ROW_BYTES = 256;
    localparam int NUM_FILTERS   = 5;
    localparam int X_W    = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int N_W    = $clog2(MAX_ROW_BYTES + 1);
    localparam int MEM_DEPTH = 3 * MAX_ROW_BYTES;
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;
    localparam logic [2:0] MODE_ADAPTIVE = 3'd5;

    localparam logic CFG_ROW_BYTES   = 1'b0;
    localparam logic CFG_FILTER_MODE = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] sample;
        logic       image_start;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_type;
        logic       row_end;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic       emit;
        logic       first;
        logic       emit_last;
        logic       score;
        logic       x0;
        logic       rs1;
        logic       rs2;
        logic       row_done;
        logic [2:0] mode;
        logic [7:0] v;
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] p;
        logic [7:0] a;
    } qent_t;

endpackage

`default_nettype wire

### design/png_rf_front.sv
// front end: config registers, row bookkeeping and the row store
`timescale 1ns / 1ps
`default_nettype none

module png_rf_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [8:0]              cfg_data,
    input  wire logic                    req_valid,
    output logic                         req_stall,
    input  wire png_rf_pkg::req_t        req,
    input  wire logic [png_rf_pkg::Q_AW:0] q_count,
    output logic                         push,
    output png_rf_pkg::qent_t            push_ent
);
    import png_rf_pkg::*;
    localparam int Q_AW_C = png_rf_pkg::Q_AW;

    logic [8:0]     row_bytes_reg;
    logic [2:0]     filter_mode_reg;
    logic [X_W-1:0] bp_reg, bp_next;
    logic [1:0]     rot_reg, rot_next;
    logic [1:0]     rs_reg, rs_next;
    logic           pv_reg, pv_next;
    logic           drain_reg, drain_next;
    logic           r_valid_reg;
    cmd_t           r_cmd_reg;
    cmd_t           cmd;
    logic           cmd_valid;
    logic [7:0]     rd_p_reg, rd_a_reg;
    logic [7:0]     mem [MEM_DEPTH];

    logic [N_W-1:0]    n;
    logic [X_W-1:0]    x, last_x;
    logic              acc, at_last, wr_en;
    logic [ADDR_W-1:0] addr_w, addr_p, addr_a;

    function automatic logic [1:0] slot_of(input logic [1:0] r, input logic [1:0] off);
        logic [2:0] s;
        s = {1'b0, r} + {1'b0, off};
        if (s >= 3'd3)
            s = s - 3'd3;
        return s[1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] s, input logic [X_W-1:0] xi);
        return ADDR_W'(s) * ADDR_W'(MAX_ROW_BYTES) + ADDR_W'(xi);
    endfunction

    always_comb
    begin
        if (row_bytes_reg == 9'd0)
            n = N_W'(1);
        else if (32'(row_bytes_reg) > 32'(MAX_ROW_BYTES))
            n = N_W'(MAX_ROW_BYTES);
        else
            n = N_W'(row_bytes_reg);
    end

    assign last_x    = X_W'(n - N_W'(1));
    assign req_stall = ({1'b0, q_count} + {{Q_AW_C + 1{1'b0}}, r_valid_reg})
                       >= (Q_AW_C + 2)'(Q_DEPTH);
    assign acc       = req_valid && !req_stall;

    always_comb
    begin
        bp_next    = bp_reg;
        rot_next   = rot_reg;
        rs_next    = rs_reg;
        pv_next    = pv_reg;
        drain_next = drain_reg;
        cmd        = '0;
        cmd_valid  = 1'b0;
        wr_en      = 1'b0;
        x          = (N_W'(bp_reg) >= n) ? last_x : bp_reg;
        cmd.mode   = filter_mode_reg;
        cmd.v      = req.sample;
        if (req.req_type)
        begin
            if (!pv_reg)
            begin
                pv_next = 1'b0; drain_next = 1'b0; rs_next = '0; bp_next = '0;
            end
            else
            begin
                drain_next = 1'b1;
                cmd_valid  = 1'b1;
                if (x == last_x)
                begin
                    pv_next = 1'b0; drain_next = 1'b0; rs_next = '0; bp_next = '0;
                end
                else
                    bp_next = x + X_W'(1);
            end
        end
        else if (req.image_start || !drain_reg)
        begin
            if (req.image_start)
            begin
                pv_next = 1'b0; drain_next = 1'b0; rs_next = '0;
                x = '0;
            end
            cmd_valid = 1'b1;
            cmd.score = 1'b1;
            wr_en     = 1'b1;
            if (x == last_x)
            begin
                cmd.row_done = 1'b1;
                pv_next  = 1'b1;
                rs_next  = (rs_next == 2'd2) ? 2'd2 : rs_next + 2'd1;
                rot_next = slot_of(rot_reg, 2'd1);
                bp_next  = '0;
            end
            else
                bp_next = x + X_W'(1);
        end
        at_last       = (x == last_x);
        // emission and gating see the row state after any image restart
        cmd.emit      = req.req_type ? 1'b1 : (pv_reg && !req.image_start);
        cmd.first     = (x == '0);
        cmd.emit_last = at_last;
        cmd.x0        = (x == '0);
        cmd.rs1       = !req.req_type && !req.image_start && (rs_reg != 2'd0);
        cmd.rs2       = (req.req_type || !req.image_start) && (rs_reg == 2'd2);
        addr_w = addr_of(rot_reg, x);
        addr_p = addr_of(slot_of(rot_reg, 2'd2), x);
        addr_a = addr_of(slot_of(rot_reg, 2'd1), x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= 9'd1;
            filter_mode_reg <= MODE_ADAPTIVE;
            bp_reg          <= '0;
            rot_reg         <= '0;
            rs_reg          <= '0;
            pv_reg          <= 1'b0;
            drain_reg       <= 1'b0;
            r_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROW_BYTES:   row_bytes_reg   <= cfg_data;
                    CFG_FILTER_MODE: filter_mode_reg <= cfg_data[2:0];
                    default:         ;
                endcase
            end
            r_valid_reg <= acc && cmd_valid;
            if (acc)
            begin
                bp_reg    <= bp_next;
                rot_reg   <= rot_next;
                rs_reg    <= rs_next;
                pv_reg    <= pv_next;
                drain_reg <= drain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            r_cmd_reg <= cmd;
            rd_p_reg  <= mem[addr_p];
            rd_a_reg  <= mem[addr_a];
            if (wr_en)
                mem[addr_w] <= req.sample;
        end
    end

    assign push         = r_valid_reg;
    assign push_ent.cmd = r_cmd_reg;
    assign push_ent.p   = rd_p_reg;
    assign push_ent.a   = rd_a_reg;

endmodule

`default_nettype wire

### design/png_rf_queue.sv
// short queue between front end and filter back end
`timescale 1ns / 1ps
`default_nettype none

module png_rf_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire png_rf_pkg::qent_t      push_ent,
    input  wire logic                   pop,
    output png_rf_pkg::qent_t           head,
    output logic                        nonempty,
    output logic [png_rf_pkg::Q_AW:0]   count
);
    import png_rf_pkg::*;

    qent_t          ent_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, rp_reg;
    logic [Q_AW:0]   cnt_reg;

    assign head     = ent_reg[rp_reg];
    assign nonempty = (cnt_reg != '0);
    assign count    = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + Q_AW'(1);
            if (pop)
                rp_reg <= rp_reg + Q_AW'(1);
            cnt_reg <= cnt_reg + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= push_ent;
    end

endmodule

`default_nettype wire

### design/png_rf_back.sv
// back end: predictors, scores, filter choice and output beats
`timescale 1ns / 1ps
`default_nettype none

module png_rf_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire png_rf_pkg::qent_t  head,
    input  wire logic               nonempty,
    output logic                    pop,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output png_rf_pkg::rsp_t        rsp
);
    import png_rf_pkg::*;

    typedef logic [NUM_FILTERS-1:0][7:0]  byte_vec_t;
    typedef logic [NUM_FILTERS-1:0][15:0] score_vec_t;

    logic [7:0] prev_p_reg, prev_a_reg, prev_v_reg;
    logic       b1_valid_reg;
    cmd_t       b1_cmd_reg;
    byte_vec_t  b1_res_reg, b1_mag_reg;
    byte_vec_t  res_c, mag_c;
    score_vec_t score_reg, score_next;
    logic [2:0] ptype_reg, ptype_next;
    rsp_t       ob0_reg, ob1_reg, ob0_next, ob1_next;
    logic [1:0] ocnt_reg, ocnt_next, ocnt_pop, nbeats;
    logic       opop, commit;
    rsp_t       type_beat, res_beat;
    logic [7:0] res_sel;

    function automatic logic [7:0] predict(input logic [2:0] f, input logic [7:0] l,
                                           input logic [7:0] u, input logic [7:0] ul);
        logic signed [10:0] pa, pb, pc;
        logic [8:0] s;
        predict = 8'd0;
        pa = $signed({3'b0, u}) - $signed({3'b0, ul});
        pb = $signed({3'b0, l}) - $signed({3'b0, ul});
        pc = pa + pb;
        s  = {1'b0, l} + {1'b0, u};
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        case (f)
            FILT_NONE: predict = 8'd0;
            FILT_SUB:  predict = l;
            FILT_UP:   predict = u;
            FILT_AVG:  predict = s[8:1];
            default:
            begin
                if (pa <= pb && pa <= pc) predict = l;
                else if (pb <= pc)        predict = u;
                else                      predict = ul;
            end
        endcase
    endfunction

    // first stage: residual candidates of the pending row, magnitudes of the new row
    always_comb
    begin
        logic [7:0] el, eu, eul, sl, su, sul, d;
        el  = head.cmd.x0 ? 8'd0 : prev_p_reg;
        eu  = head.cmd.rs2 ? head.a : 8'd0;
        eul = (head.cmd.rs2 && !head.cmd.x0) ? prev_a_reg : 8'd0;
        sl  = head.cmd.x0 ? 8'd0 : prev_v_reg;
        su  = head.cmd.rs1 ? head.p : 8'd0;
        sul = (head.cmd.rs1 && !head.cmd.x0) ? prev_p_reg : 8'd0;
        for (int f = 0; f < NUM_FILTERS; f++)
        begin
            res_c[f] = head.p - predict(3'(f), el, eu, eul);
            d        = head.cmd.v - predict(3'(f), sl, su, sul);
            mag_c[f] = d[7] ? 8'(-d) : d;
        end
    end

    assign nbeats   = b1_cmd_reg.emit ? (b1_cmd_reg.first ? 2'd2 : 2'd1) : 2'd0;
    assign opop     = rsp_valid && !rsp_stall;
    assign ocnt_pop = ocnt_reg - {1'b0, opop};
    assign commit   = b1_valid_reg && ({1'b0, nbeats} + {1'b0, ocnt_pop} <= 3'd2);
    assign pop      = nonempty && (!b1_valid_reg || commit);

    // second stage: score update, type choice at row end, beats out
    always_comb
    begin
        logic [16:0] s;
        logic [2:0]  sel;
        for (int f = 0; f < NUM_FILTERS; f++)
        begin
            s = (b1_cmd_reg.x0 ? 17'd0 : {1'b0, score_reg[f]}) + {9'd0, b1_mag_reg[f]};
            score_next[f] = s[16] ? 16'hFFFF : s[15:0];
        end
        sel = FILT_NONE;
        for (int f = 1; f < NUM_FILTERS; f++)
            if (score_next[f] < score_next[sel])
                sel = 3'(f);
        ptype_next = (b1_cmd_reg.mode < MODE_ADAPTIVE) ? b1_cmd_reg.mode : sel;
    end

    always_comb
    begin
        case (ptype_reg)
            FILT_NONE:  res_sel = b1_res_reg[0];
            FILT_SUB:   res_sel = b1_res_reg[1];
            FILT_UP:    res_sel = b1_res_reg[2];
            FILT_AVG:   res_sel = b1_res_reg[3];
            default:    res_sel = b1_res_reg[4];
        endcase
        type_beat = '{out_byte: {5'd0, ptype_reg}, is_type: 1'b1, row_end: 1'b0, last: 1'b0};
        res_beat  = '{out_byte: res_sel, is_type: 1'b0,
                      row_end: b1_cmd_reg.emit_last, last: 1'b1};
        ob0_next  = ob0_reg;
        ob1_next  = ob1_reg;
        ocnt_next = ocnt_pop;
        if (opop)
            ob0_next = ob1_reg;
        if (commit)
        begin
            if (nbeats == 2'd2)
            begin
                ob0_next = type_beat;
                ob1_next = res_beat;
            end
            else if (nbeats == 2'd1)
            begin
                if (ocnt_pop == 2'd0) ob0_next = res_beat;
                else                  ob1_next = res_beat;
            end
            ocnt_next = ocnt_pop + nbeats;
        end
    end

    assign rsp_valid = (ocnt_reg != 2'd0);
    assign rsp       = ob0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            ocnt_reg     <= '0;
            score_reg    <= '0;
            ptype_reg    <= FILT_NONE;
        end
        else
        begin
            ocnt_reg <= ocnt_next;
            if (pop)
                b1_valid_reg <= 1'b1;
            else if (commit)
                b1_valid_reg <= 1'b0;
            if (commit && b1_cmd_reg.score)
                score_reg <= score_next;
            if (commit && b1_cmd_reg.row_done)
                ptype_reg <= ptype_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob0_reg <= ob0_next;
        ob1_reg <= ob1_next;
        if (pop)
        begin
            b1_cmd_reg <= head.cmd;
            b1_res_reg <= res_c;
            b1_mag_reg <= mag_c;
            prev_p_reg <= head.p;
            prev_a_reg <= head.a;
            prev_v_reg <= head.cmd.v;
        end
    end

endmodule

`default_nettype wire

### design/png_row_filter_adaptive.sv
// top level of the streaming png row filter with adaptive type choice
`timescale 1ns / 1ps
`default_nettype none

// Streaming PNG scanline filter. Sample bytes come in one beat per cycle
// unless stalled; a finished row is emitted while the next row arrives, as
// a filter type beat followed by one residual beat per byte, so a row of n
// bytes leaves as n+1 beats and, with the output side always ready, the
// input runs at n/(n+1) beats per cycle, set by the single output beat per
// cycle. Flush beats drain the last row. The row store holds three rows in
// one memory with one write port and two read ports; it is not cleared
// after reset and needs no clearing pass. Config writes (row_bytes,
// filter_mode) must go in only while the block is idle, unchecked by the
// block; filter_mode 5 to 7 picks the type with the least sum of absolute
// residuals, lower type on a tie.
module png_row_filter_adaptive (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [8:0]        cfg_data,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire png_rf_pkg::req_t  req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output png_rf_pkg::rsp_t       rsp
);
    import png_rf_pkg::*;

    // front to queue
    logic          push;
    qent_t         push_ent;
    // queue to back
    qent_t         head;
    logic          nonempty, pop;
    logic [Q_AW:0] q_count;

    // row bookkeeping, config and row store reads
    png_rf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_count   (q_count),
        .push      (push),
        .push_ent  (push_ent)
    );

    // decouples the front end from output stalls
    png_rf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty),
        .count    (q_count)
    );

    // filters, scores and output beats
    png_rf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .nonempty  (nonempty),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
